// ===== rtl/minmax_normalize_binarize_core_assert.svh =====
// Assertion macros for the min-max normalize and binarize core.
`ifndef MINMAX_NORMALIZE_BINARIZE_CORE_ASSERT_SVH
`define MINMAX_NORMALIZE_BINARIZE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MNB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MNB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mnb_pkg.sv =====
// Shared types and constants for the min-max normalize and binarize core.
package mnb_pkg;

    localparam int unsigned PIX_W     = 8;
    localparam int unsigned BOUND_W   = PIX_W + 1;
    localparam int unsigned QUOT_BITS = PIX_W;
    localparam int unsigned CNT_W     = $clog2(QUOT_BITS);

    localparam logic [PIX_W-1:0]   FULL_SCALE      = 8'd255;
    localparam logic [PIX_W-1:0]   THRESHOLD_RESET = 8'd128;
    localparam logic [BOUND_W-1:0] RUN_MIN_EMPTY   = 9'd256;
    localparam logic [BOUND_W-1:0] RUN_MAX_EMPTY   = 9'h1FF;

    // Input item codes for the func field
    localparam logic FUNC_MEASURE = 1'b0;
    localparam logic FUNC_CONVERT = 1'b1;

    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] pixel;
        logic             end_of_pass;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] bin_pixel;
        logic             last_pixel;
    } t_out_item;

endpackage

// ===== rtl/minmax_normalize_binarize_core.sv =====
// Top level: min-max normalization with inverted threshold on 8-bit pixels.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready| o_out_data (t_out_item)
//  cfg     | input     | i_cfg_we                 | i_cfg_wdata (threshold)
//
// A measure pixel leaves the block ready in the next cycle.
// A convert pixel is loaded, then takes eight restoring-division steps through
// one shared 10-bit compare/subtract unit, then loads the output register.
// The output register frees the input side while a result waits; a convert
// pixel stalls in its final cycle only while the previous result is untaken.
// Reset (i_rst_n low, synchronous) restores empty trackers, bounds 0 and 255,
// threshold 128.
module minmax_normalize_binarize_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mnb_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mnb_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata
);

`include "minmax_normalize_binarize_core_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } t_state;

    t_state                          r_state, n_state;
    logic [mnb_pkg::BOUND_W-1:0]     r_run_min, n_run_min;
    logic [mnb_pkg::BOUND_W-1:0]     r_run_max, n_run_max;
    logic [mnb_pkg::PIX_W-1:0]       r_frame_min, n_frame_min;
    logic [mnb_pkg::BOUND_W-1:0]     r_frame_max, n_frame_max;
    logic [mnb_pkg::PIX_W-1:0]       r_thr, n_thr;
    logic [mnb_pkg::BOUND_W-1:0]     r_span, n_span;
    logic [mnb_pkg::BOUND_W-1:0]     r_rem, n_rem;
    logic [mnb_pkg::PIX_W-1:0]       r_shift, n_shift;
    logic [mnb_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic                            r_low, n_low;
    logic                            r_high, n_high;
    logic                            r_last, n_last;
    logic                            r_out_valid, n_out_valid;
    mnb_pkg::t_out_item              r_out_data, n_out_data;

    logic                            in_xfer;
    logic [mnb_pkg::BOUND_W-1:0]     pix9;
    logic [mnb_pkg::BOUND_W-1:0]     fmin9;
    logic [mnb_pkg::BOUND_W-1:0]     meas_min;
    logic [mnb_pkg::BOUND_W-1:0]     meas_max;
    logic [mnb_pkg::PIX_W-1:0]       diff8;
    logic [2*mnb_pkg::PIX_W-1:0]     prod16;
    logic [mnb_pkg::BOUND_W:0]       trial;
    logic [mnb_pkg::BOUND_W:0]       trial_sub;
    logic                            fits;
    logic [mnb_pkg::PIX_W-1:0]       level;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Running bounds including the incoming pixel; run_max is signed (-1 = empty)
    assign pix9     = {1'b0, i_in_data.pixel};
    assign fmin9    = {1'b0, r_frame_min};
    assign meas_min = (pix9 < r_run_min) ? pix9 : r_run_min;
    assign meas_max = ($signed(pix9) > $signed(r_run_max)) ? pix9 : r_run_max;

    // Scaled difference (p - min) * 255 as (d << 8) - d
    assign diff8  = i_in_data.pixel - r_frame_min;
    assign prod16 = {diff8, {mnb_pkg::PIX_W{1'b0}}} - {{mnb_pkg::PIX_W{1'b0}}, diff8};

    // Shared compare/subtract unit: one quotient bit per step
    assign trial     = {r_rem, r_shift[mnb_pkg::PIX_W-1]};
    assign trial_sub = trial - {1'b0, r_span};
    assign fits      = (trial >= {1'b0, r_span});

    // Saturate below min and at or above max, else take the quotient
    assign level = r_low  ? '0 :
                   r_high ? mnb_pkg::FULL_SCALE : r_shift;

    always_comb begin
        n_state     = r_state;
        n_run_min   = r_run_min;
        n_run_max   = r_run_max;
        n_frame_min = r_frame_min;
        n_frame_max = r_frame_max;
        n_thr       = r_thr;
        n_span      = r_span;
        n_rem       = r_rem;
        n_shift     = r_shift;
        n_cnt       = r_cnt;
        n_low       = r_low;
        n_high      = r_high;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        // Drop the result once its transfer completes
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            n_thr = i_cfg_wdata;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in_data.func == mnb_pkg::FUNC_MEASURE) begin
                        // Track bounds; latch them on the pass end
                        if (i_in_data.end_of_pass) begin
                            n_frame_min = meas_min[mnb_pkg::PIX_W-1:0];
                            n_frame_max = (meas_max == meas_min) ?
                                          meas_max + mnb_pkg::BOUND_W'(1) : meas_max;
                            n_run_min   = mnb_pkg::RUN_MIN_EMPTY;
                            n_run_max   = mnb_pkg::RUN_MAX_EMPTY;
                        end else begin
                            n_run_min = meas_min;
                            n_run_max = meas_max;
                        end
                    end else begin
                        // Load the divider
                        n_low   = (pix9 <= fmin9);
                        n_span  = r_frame_max - fmin9;
                        n_high  = ({1'b0, diff8} >= (r_frame_max - fmin9));
                        n_rem   = {1'b0, prod16[2*mnb_pkg::PIX_W-1:mnb_pkg::PIX_W]};
                        n_shift = prod16[mnb_pkg::PIX_W-1:0];
                        n_last  = i_in_data.end_of_pass;
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                // Advance one restoring-division step
                n_rem   = fits ? trial_sub[mnb_pkg::BOUND_W-1:0]
                               : trial[mnb_pkg::BOUND_W-1:0];
                n_shift = {r_shift[mnb_pkg::PIX_W-2:0], fits};
                n_cnt   = r_cnt + mnb_pkg::CNT_W'(1);
                if (r_cnt == mnb_pkg::CNT_W'(mnb_pkg::QUOT_BITS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // Hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid           = 1'b1;
                    n_out_data.bin_pixel  = (level > r_thr) ? '0 : mnb_pkg::FULL_SCALE;
                    n_out_data.last_pixel = r_last;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run_min   <= mnb_pkg::RUN_MIN_EMPTY;
            r_run_max   <= mnb_pkg::RUN_MAX_EMPTY;
            r_frame_min <= '0;
            r_frame_max <= {1'b0, mnb_pkg::FULL_SCALE};
            r_thr       <= mnb_pkg::THRESHOLD_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run_min   <= n_run_min;
            r_run_max   <= n_run_max;
            r_frame_min <= n_frame_min;
            r_frame_max <= n_frame_max;
            r_thr       <= n_thr;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_span     <= n_span;
        r_rem      <= n_rem;
        r_shift    <= n_shift;
        r_low      <= n_low;
        r_high     <= n_high;
        r_last     <= n_last;
        r_out_data <= n_out_data;
    end

    // Divisor must never be zero
    `MNB_ASSERT_NOW(a_span_nonzero, 1'b1, r_frame_max > fmin9, "frame bounds not ordered")
    // A convert pixel keeps the block busy the next cycle
    `MNB_ASSERT_NEXT(a_convert_busy, in_xfer && i_in_data.func == mnb_pkg::FUNC_CONVERT,
        !o_in_ready, "block ready right after a convert pixel")
    // A measure pixel yields no result
    `MNB_ASSERT_NEXT(a_measure_silent,
        in_xfer && i_in_data.func == mnb_pkg::FUNC_MEASURE && !r_out_valid,
        !o_out_valid, "result produced by a measure pixel")
    // Results appear only out of the final sequencer step
    `MNB_ASSERT_NOW(a_result_source, $rose(o_out_valid), $past(r_state) == S_FIN,
        "result raised outside the final step")

endmodule

// ===== bench/minmax_normalize_binarize_core_tb.sv =====
// Self-checking testbench for the min-max normalize and binarize core.
module minmax_normalize_binarize_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NUM_PHASES     = 6;
    localparam int          PHASE_ITEMS    = 172;
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DIR_ROWS       = 22;
    localparam int          TRK_MAX_EMPTY  = -1;
    localparam logic [7:0]  BIN_DARK       = 8'd0;
    localparam logic [7:0]  BIN_LIGHT      = 8'd255;

    typedef struct {
        mnb_pkg::t_in_item  pix;
        bit                 typed;
        mnb_pkg::t_out_item res;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    mnb_pkg::t_in_item  i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b1;
    mnb_pkg::t_out_item o_out_data;
    logic               i_cfg_we = 1'b0;
    logic [7:0]         i_cfg_wdata = '0;

    // Predictor state: running trackers, latched bounds, threshold
    int           trk_min = int'(mnb_pkg::RUN_MIN_EMPTY);
    int           trk_max = TRK_MAX_EMPTY;
    logic [7:0]   bnd_min = 8'd0;
    logic [8:0]   bnd_max = {1'b0, mnb_pkg::FULL_SCALE};
    logic [7:0]   thr     = mnb_pkg::THRESHOLD_RESET;

    mnb_pkg::t_out_item expected_bins [$];
    int           fail_cnt    = 0;
    int           items_sent  = 0;
    int           quiet_cycles = 0;
    int           stall_left  = 0;
    bit           idle_on     = 1'b1;
    t_dir_row     dir_tab [DIR_ROWS];

    minmax_normalize_binarize_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // Normalized level of a pixel against the latched bounds, saturated to 0..255
    function automatic logic [7:0] norm_level(input logic [7:0] p);
        int span;
        int diff;
        int lvl;
        span = int'(bnd_max) - int'(bnd_min);
        diff = int'(p) - int'(bnd_min);
        if (span <= 0) span = 1;
        if (diff <= 0) return 8'd0;
        lvl = diff * int'(mnb_pkg::FULL_SCALE) / span;
        if (lvl > int'(mnb_pkg::FULL_SCALE)) lvl = int'(mnb_pkg::FULL_SCALE);
        return lvl[7:0];
    endfunction

    // Track bounds on measure pixels, binarize convert pixels
    function automatic void track_and_binarize(input mnb_pkg::t_in_item it,
                                               output bit has_res,
                                               output mnb_pkg::t_out_item res);
        has_res = 1'b0;
        res     = '0;
        if (it.func == mnb_pkg::FUNC_MEASURE) begin
            if (int'(it.pixel) < trk_min) trk_min = int'(it.pixel);
            if (int'(it.pixel) > trk_max) trk_max = int'(it.pixel);
            if (it.end_of_pass) begin
                bnd_min = trk_min[7:0];
                bnd_max = trk_max[8:0];
                // flat frame: widen by one so the span is never zero
                if (bnd_max == {1'b0, bnd_min}) bnd_max = {1'b0, bnd_min} + 9'd1;
                trk_min = int'(mnb_pkg::RUN_MIN_EMPTY);
                trk_max = TRK_MAX_EMPTY;
            end
        end else begin
            has_res        = 1'b1;
            res.bin_pixel  = (norm_level(it.pixel) > thr) ? BIN_DARK : BIN_LIGHT;
            res.last_pixel = it.end_of_pass;
        end
    endfunction

    function automatic t_dir_row mk_row(input logic f, input logic [7:0] p, input logic e,
                                        input bit typed, input logic [7:0] b);
        t_dir_row r;
        r.pix.func           = f;
        r.pix.pixel          = p;
        r.pix.end_of_pass    = e;
        r.typed              = typed;
        r.res.bin_pixel      = b;
        r.res.last_pixel     = e;
        return r;
    endfunction

    // Output side stalls in random bursts
    always @(posedge i_clk) begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 11) == 0)
            stall_left = $urandom_range(1, 19);
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        mnb_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_bins.size() == 0) begin
                if (fail_cnt < 10)
                    $display("ERROR: unexpected result bin=%0d last=%0b",
                             o_out_data.bin_pixel, o_out_data.last_pixel);
                fail_cnt++;
            end else begin
                want = expected_bins.pop_front();
                if (o_out_data.bin_pixel !== want.bin_pixel ||
                    o_out_data.last_pixel !== want.last_pixel) begin
                    if (fail_cnt < 10)
                        $display("ERROR: expected bin=%0d last=%0b, got bin=%0d last=%0b",
                                 want.bin_pixel, want.last_pixel,
                                 o_out_data.bin_pixel, o_out_data.last_pixel);
                    fail_cnt++;
                end
            end
        end
    end

    // Abort when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one pixel, hold it until the transfer, then predict
    task automatic send_pixel(input mnb_pkg::t_in_item it, input bit typed,
                              input mnb_pkg::t_out_item typed_res);
        bit                 has_res;
        mnb_pkg::t_out_item res;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        track_and_binarize(it, has_res, res);
        if (has_res) expected_bins.push_back(typed ? typed_res : res);
        items_sent++;
    endtask

    task automatic send_rand(input logic f, input logic [7:0] p, input logic e);
        mnb_pkg::t_in_item it;
        it.func        = f;
        it.pixel       = p;
        it.end_of_pass = e;
        send_pixel(it, 1'b0, '0);
    endtask

    // One well-formed frame: measure pass then convert pass, random content
    task automatic send_frame();
        int n;
        int lo;
        int hi;
        int k;
        logic [7:0] p;
        case ($urandom_range(0, 3))
            0: begin
                lo = 0;
                hi = 255;
            end
            1: begin
                lo = $urandom_range(0, 255);
                hi = (lo + 8 > 255) ? 255 : $urandom_range(lo, lo + 8);
            end
            2: begin
                lo = $urandom_range(0, 255);
                hi = lo;
            end
            default: begin
                lo = $urandom_range(0, 255);
                hi = $urandom_range(lo, 255);
            end
        endcase
        n = $urandom_range(1, 12);
        for (k = 0; k < n; k++)
            send_rand(mnb_pkg::FUNC_MEASURE, 8'($urandom_range(lo, hi)), k == n - 1);
        n = $urandom_range(1, 12);
        for (k = 0; k < n; k++) begin
            p = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(lo, hi));
            send_rand(mnb_pkg::FUNC_CONVERT, p, k == n - 1);
        end
    endtask

    // Free-form items: broken passes, stray markers
    task automatic send_noise();
        repeat ($urandom_range(1, 4))
            send_rand(1'($urandom), 8'($urandom), ($urandom_range(0, 3) == 0));
    endtask

    // Drop valid, wait out every expectation, then let the core settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_bins.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_threshold(input logic [7:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        thr = v;
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int ph;
        int phase_end;
        logic [7:0] tv;

        // Directed rows; typed results hold at threshold 128, at reset bounds 0..255 until a frame latches new ones
        dir_tab = '{
            // convert before any measure: level equals the pixel
            mk_row(mnb_pkg::FUNC_CONVERT, 8'd0,   1'b0, 1'b1, BIN_LIGHT),
            mk_row(mnb_pkg::FUNC_CONVERT, 8'd255, 1'b0, 1'b1, BIN_DARK),
            mk_row(mnb_pkg::FUNC_CONVERT, 8'd128, 1'b0, 1'b1, BIN_LIGHT),
            mk_row(mnb_pkg::FUNC_CONVERT, 8'd129, 1'b1, 1'b1, BIN_DARK),
            // frame with bounds 10..240
            mk_row(mnb_pkg::FUNC_MEASURE, 8'd50,  1'b0, 1'b0, BIN_DARK),
            mk_row(mnb_pkg::FUNC_MEASURE, 8'd200, 1'b0, 1'b0, BIN_DARK),
            mk_row(mnb_pkg::FUNC_MEASURE, 8'd10,  1'b0, 1'b0, BIN_DARK),
            mk_row(mnb_pkg::FUNC_MEASURE, 8'd240, 1'b1, 1'b0, BIN_DARK),
            // below min saturates low, at and above max saturate high
            mk_row(mnb_pkg::FUNC_CONVERT, 8'd5,   1'b0, 1'b1, BIN_LIGHT),
            mk_row(mnb_pkg::FUNC_CONVERT, 8'd10,  1'b0, 1'b1, BIN_LIGHT),
            mk_row(mnb_pkg::FUNC_CONVERT, 8'd240, 1'b0, 1'b1, BIN_DARK),
            mk_row(mnb_pkg::FUNC_CONVERT, 8'd250, 1'b0, 1'b1, BIN_DARK),
            mk_row(mnb_pkg::FUNC_CONVERT, 8'd125, 1'b0, 1'b0, BIN_DARK),
            mk_row(mnb_pkg::FUNC_CONVERT, 8'd126, 1'b1, 1'b0, BIN_DARK),
            // flat frame of full white: max becomes 256
            mk_row(mnb_pkg::FUNC_MEASURE, 8'd255, 1'b0, 1'b0, BIN_DARK),
            mk_row(mnb_pkg::FUNC_MEASURE, 8'd255, 1'b1, 1'b0, BIN_DARK),
            mk_row(mnb_pkg::FUNC_CONVERT, 8'd255, 1'b0, 1'b1, BIN_LIGHT),
            mk_row(mnb_pkg::FUNC_CONVERT, 8'd254, 1'b1, 1'b1, BIN_LIGHT),
            // single-pixel flat frame of black: span of one
            mk_row(mnb_pkg::FUNC_MEASURE, 8'd0,   1'b1, 1'b0, BIN_DARK),
            mk_row(mnb_pkg::FUNC_CONVERT, 8'd1,   1'b0, 1'b1, BIN_DARK),
            mk_row(mnb_pkg::FUNC_CONVERT, 8'd0,   1'b0, 1'b1, BIN_LIGHT),
            mk_row(mnb_pkg::FUNC_CONVERT, 8'd200, 1'b1, 1'b1, BIN_DARK)
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++)
            send_pixel(dir_tab[r].pix, dir_tab[r].typed, dir_tab[r].res);

        // Random phases, each under its own threshold; last phase runs without idling
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            idle_on = (ph != NUM_PHASES - 1);
            case (ph)
                0:       tv = 8'd0;
                1:       tv = 8'd255;
                default: tv = 8'($urandom);
            endcase
            set_threshold(tv);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 6) == 0) send_noise();
                else send_frame();
            end
        end
        drain_results();

        if (fail_cnt == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== minmax_normalize_binarize_core.f =====
+incdir+rtl
rtl/mnb_pkg.sv
rtl/minmax_normalize_binarize_core.sv
bench/minmax_normalize_binarize_core_tb.sv
